### design/maps_pkg.sv
`default_nettype none

package maps_pkg;

   localparam int ATAN_LEN = 24;
   localparam int ATAN_W   = 30;

   // atan(2^-i) in binary angle units, 2^32 units to one full turn.
   localparam logic [ATAN_W-1:0] ATAN_TABLE [ATAN_LEN] = '{
      30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756,
      30'd42667331,  30'd21354465,  30'd10679838,  30'd5340245,
      30'd2670163,   30'd1335087,   30'd667544,    30'd333772,
      30'd166886,    30'd83443,     30'd41722,     30'd20861,
      30'd10430,     30'd5215,      30'd2608,      30'd1304,
      30'd652,       30'd326,       30'd163,       30'd81
   };

   localparam int RAW_W       = 12;
   localparam int FRAC_W      = 16;
   localparam int DEG_W       = 9;
   localparam int CSR_INDEX_W = 1;

   localparam logic [CSR_INDEX_W-1:0] CSR_TARGET_DEGREE     = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TOLERANCE_DEGREES = 1'b1;

   localparam logic [DEG_W-1:0] TARGET_RESET  = 9'd90;
   localparam logic [DEG_W-1:0] TOL_RESET     = 9'd4;
   localparam logic [DEG_W-1:0] DEG_QUARTER   = 9'd90;
   localparam logic [DEG_W-1:0] DEG_HALF      = 9'd180;
   localparam logic [DEG_W-1:0] DEG_THREE_Q   = 9'd270;
   localparam logic [DEG_W-1:0] DEG_FULL      = 9'd360;

   typedef struct packed {
      logic [7:0] x_high_byte;
      logic [7:0] y_high_byte;
      logic [7:0] xy_low_nibbles;
   } req_word_type;

   typedef struct packed {
      logic [DEG_W-1:0] angle_degree;
      logic             motor_run;
   } rsp_word_type;

endpackage

`default_nettype wire

### design/magnet_angle_position_stop_unit.sv
// Magnet angle position stop unit.
// The req channel takes one word per sensor sample: the X and Y high bytes and
// a byte that holds both low nibbles. The rsp channel returns one word per
// sample: the angle in whole degrees, 0 to 360, and the motor run bit, which is
// set when the angle differs from the target by more than the tolerance.
// The csr port writes the target (index 0) or the tolerance (index 1).
// Write them only while no sample is in flight: the block does not enforce it.
// The angle comes from a CORDIC pipeline with one register stage per iteration.
// A word passes the CORDIC stage registers, then the unit-angle, degree and
// output registers. One word is accepted in every cycle while the pipeline
// advances, as the fully pipelined CORDIC gives each iteration its own stage.
// When the receiver stalls, the result stays in the output register and the
// pipeline moves only while the stage in front of the output register is
// empty, so new words are still accepted until that stage is full.
// A synchronous reset empties the pipeline and sets the target to 90 degrees
// and the tolerance to 4 degrees.
`default_nettype none

module magnet_angle_position_stop_unit
   import maps_pkg::*;
#(
   parameter int CORDIC_STEPS = 16
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire req_word_type           req_data,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output rsp_word_type                rsp_data,
   input  wire logic                   csr_we,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [DEG_W-1:0]       csr_wdata
);

   localparam int CW     = 32;
   localparam int AW     = 34;
   localparam int UW     = 33;
   localparam int PW     = UW + DEG_W;
   localparam int NSTAGE = CORDIC_STEPS + 3;
   localparam int USTG   = CORDIC_STEPS + 1;
   localparam int LAST   = NSTAGE - 1;

   localparam logic signed [AW-1:0] HALF_TURN = AW'(64'sh8000_0000);
   localparam logic signed [AW-1:0] FULL_TURN = AW'(64'sh1_0000_0000);

   logic [DEG_W-1:0] target_ff;
   logic [DEG_W-1:0] tolerance_ff;

   logic                   vld_ff      [NSTAGE];
   logic                   spec_ff     [NSTAGE-1];
   logic [DEG_W-1:0]       spec_ang_ff [NSTAGE-1];
   logic signed [CW-1:0]   x_ff        [CORDIC_STEPS+1];
   logic signed [CW-1:0]   y_ff        [CORDIC_STEPS+1];
   logic signed [AW-1:0]   a_ff        [CORDIC_STEPS+1];
   logic signed [CW-1:0]   x_in        [CORDIC_STEPS+1];
   logic signed [CW-1:0]   y_in        [CORDIC_STEPS+1];
   logic signed [AW-1:0]   a_in        [CORDIC_STEPS+1];
   logic [UW-1:0]          u_ff;
   logic [UW-1:0]          u_in;
   logic [DEG_W-1:0]       deg_ff;
   logic [DEG_W-1:0]       deg_in;
   logic                   rsp_valid_ff;
   rsp_word_type           rsp_data_ff;
   rsp_word_type           rsp_data_in;

   logic signed [RAW_W-1:0] xs;
   logic signed [RAW_W-1:0] ys;
   logic signed [CW-1:0]    x_scaled;
   logic signed [CW-1:0]    y_scaled;
   logic                    spec_in;
   logic [DEG_W-1:0]        spec_ang_in;
   logic signed [AW-1:0]    u_sum;
   logic [PW-1:0]           prod;
   logic [DEG_W-1:0]        deg_err;
   logic                    advance;
   logic                    out_load;

   assign out_load  = !rsp_valid_ff || rsp_ready;
   assign advance   = !vld_ff[LAST] || out_load;
   assign req_ready = advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff    <= TARGET_RESET;
         tolerance_ff <= TOL_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_TARGET_DEGREE:     target_ff    <= csr_wdata;
            CSR_TOLERANCE_DEGREES: tolerance_ff <= csr_wdata;
         endcase
      end
   end

   always_comb begin
      xs = signed'({req_data.x_high_byte, req_data.xy_low_nibbles[7:4]});
      ys = signed'({req_data.y_high_byte, req_data.xy_low_nibbles[3:0]});
      x_scaled = signed'({{(CW-RAW_W-FRAC_W){xs[RAW_W-1]}}, xs, {FRAC_W{1'b0}}});
      y_scaled = signed'({{(CW-RAW_W-FRAC_W){ys[RAW_W-1]}}, ys, {FRAC_W{1'b0}}});
      spec_in = (ys == '0) || (xs == '0);
      if (ys == '0) begin
         spec_ang_in = xs[RAW_W-1] ? DEG_FULL : DEG_HALF;
      end else begin
         spec_ang_in = ys[RAW_W-1] ? DEG_QUARTER : DEG_THREE_Q;
      end
      if (xs[RAW_W-1]) begin
         x_in[0] = -x_scaled;
         y_in[0] = -y_scaled;
         a_in[0] = ys[RAW_W-1] ? -HALF_TURN : HALF_TURN;
      end else begin
         x_in[0] = x_scaled;
         y_in[0] = y_scaled;
         a_in[0] = '0;
      end
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         if (!y_ff[i][CW-1] && (y_ff[i] != '0)) begin
            x_in[i+1] = x_ff[i] + (y_ff[i] >>> i);
            y_in[i+1] = y_ff[i] - (x_ff[i] >>> i);
            a_in[i+1] = a_ff[i] + signed'(AW'(ATAN_TABLE[i]));
         end else begin
            x_in[i+1] = x_ff[i] - (y_ff[i] >>> i);
            y_in[i+1] = y_ff[i] + (x_ff[i] >>> i);
            a_in[i+1] = a_ff[i] - signed'(AW'(ATAN_TABLE[i]));
         end
      end
   end

   always_comb begin
      u_sum = a_ff[CORDIC_STEPS] + HALF_TURN;
      if (u_sum[AW-1]) begin
         u_in = '0;
      end else if (u_sum > FULL_TURN) begin
         u_in = UW'(FULL_TURN);
      end else begin
         u_in = UW'(u_sum);
      end
      prod = PW'(u_ff) * PW'(DEG_FULL);
      deg_in = spec_ff[USTG] ? spec_ang_ff[USTG] : prod[CW +: DEG_W];
      deg_err = (deg_ff >= target_ff) ? (deg_ff - target_ff) : (target_ff - deg_ff);
      rsp_data_in.angle_degree = deg_ff;
      rsp_data_in.motor_run    = deg_err > tolerance_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NSTAGE; k++) begin
            vld_ff[k] <= 1'b0;
         end
      end else if (advance) begin
         vld_ff[0] <= req_valid;
         for (int k = 1; k < NSTAGE; k++) begin
            vld_ff[k] <= vld_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         spec_ff[0]     <= spec_in;
         spec_ang_ff[0] <= spec_ang_in;
         for (int k = 1; k < NSTAGE-1; k++) begin
            spec_ff[k]     <= spec_ff[k-1];
            spec_ang_ff[k] <= spec_ang_ff[k-1];
         end
         for (int i = 0; i <= CORDIC_STEPS; i++) begin
            x_ff[i] <= x_in[i];
            y_ff[i] <= y_in[i];
            a_ff[i] <= a_in[i];
         end
         u_ff   <= u_in;
         deg_ff <= deg_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= vld_ff[LAST];
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   a_angle_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.angle_degree <= DEG_FULL)
      else $error("angle above full turn");

   a_on_target_stops: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.angle_degree == target_ff) |-> !rsp_data.motor_run)
      else $error("motor runs at zero angle error");

   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> vld_ff[0])
      else $error("accepted word not in first stage");

   a_stall_holds_tail: assert property (@(posedge clock) disable iff (reset)
      vld_ff[LAST] && !advance |=> vld_ff[LAST])
      else $error("stalled word lost from last stage");

endmodule

`default_nettype wire

### sim/magnet_angle_position_stop_unit_test.sv
`default_nettype none

module magnet_angle_position_stop_unit_test;
   import maps_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CORDIC_STEPS = 16;
   localparam int PERIOD       = 10;
   localparam int HOLD_CYCLES  = 300;
   localparam longint HALF_TURN_UNITS = 64'sd2147483648;
   localparam longint FULL_TURN_UNITS = 64'sd4294967296;

   typedef struct {
      logic [11:0] x_field;
      logic [11:0] y_field;
      bit          known;
      logic [8:0]  angle;
      logic        run;
   } dir_row_type;

   typedef struct {
      bit           known;
      rsp_word_type word;
   } note_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   req_word_type           req_data = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   rsp_word_type           rsp_data;
   logic                   csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_TARGET_DEGREE;
   logic [DEG_W-1:0]       csr_wdata = '0;

   longint arctan_units [24] = '{
      536870912, 316933406, 167458907, 85004756,
      42667331,  21354465,  10679838,  5340245,
      2670163,   1335087,   667544,    333772,
      166886,    83443,     41722,     20861,
      10430,     5215,      2608,      1304,
      652,       326,       163,       81
   };

   dir_row_type directed_rows [24] = '{
      '{12'h000, 12'h000, 1'b1, 9'd180, 1'b1},
      '{12'h7FF, 12'h000, 1'b1, 9'd180, 1'b1},
      '{12'h001, 12'h000, 1'b1, 9'd180, 1'b1},
      '{12'h800, 12'h000, 1'b1, 9'd360, 1'b1},
      '{12'hFFF, 12'h000, 1'b1, 9'd360, 1'b1},
      '{12'h000, 12'h7FF, 1'b1, 9'd270, 1'b1},
      '{12'h000, 12'h001, 1'b1, 9'd270, 1'b1},
      '{12'h000, 12'h800, 1'b1, 9'd90,  1'b0},
      '{12'h000, 12'hFFF, 1'b1, 9'd90,  1'b0},
      '{12'h7FF, 12'h7FF, 1'b0, 9'd0,   1'b0},
      '{12'h800, 12'h800, 1'b0, 9'd0,   1'b0},
      '{12'h800, 12'h7FF, 1'b0, 9'd0,   1'b0},
      '{12'h7FF, 12'h800, 1'b0, 9'd0,   1'b0},
      '{12'h001, 12'h001, 1'b0, 9'd0,   1'b0},
      '{12'hFFF, 12'hFFF, 1'b0, 9'd0,   1'b0},
      '{12'hFFF, 12'h001, 1'b0, 9'd0,   1'b0},
      '{12'h001, 12'hFFF, 1'b0, 9'd0,   1'b0},
      '{12'h7FF, 12'h001, 1'b0, 9'd0,   1'b0},
      '{12'h7FF, 12'hFFF, 1'b0, 9'd0,   1'b0},
      '{12'h800, 12'h001, 1'b0, 9'd0,   1'b0},
      '{12'h800, 12'hFFF, 1'b0, 9'd0,   1'b0},
      '{12'hAAA, 12'h555, 1'b0, 9'd0,   1'b0},
      '{12'h555, 12'hAAA, 1'b0, 9'd0,   1'b0},
      '{12'h0F0, 12'hF0F, 1'b0, 9'd0,   1'b0}
   };

   logic [DEG_W-1:0] target_setting = TARGET_RESET;
   logic [DEG_W-1:0] tolerance_setting = TOL_RESET;
   rsp_word_type     pending_angles [$];
   note_type         pending_notes [$];
   rsp_word_type     wanted_word;
   note_type         sent_note;
   int               mismatch_count = 0;
   bit               hold_wanted = 1'b0;
   bit               hold_done = 1'b0;

   magnet_angle_position_stop_unit #(
      .CORDIC_STEPS(CORDIC_STEPS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #(PERIOD / 2) clock = ~clock;

   function automatic logic [8:0] cordic_degrees(logic signed [11:0] xs, logic signed [11:0] ys);
      longint x, y, a, u, dx, dy, d;
      int     i;
      if (ys == 0) return (xs < 0) ? 9'd360 : 9'd180;
      if (xs == 0) return (ys > 0) ? 9'd270 : 9'd90;
      x = longint'(xs) * 65536;
      y = longint'(ys) * 65536;
      a = 0;
      if (x < 0) begin
         a = (y >= 0) ? HALF_TURN_UNITS : -HALF_TURN_UNITS;
         x = -x;
         y = -y;
      end
      for (i = 0; i < CORDIC_STEPS && i < 24; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (y > 0) begin
            x = x + dx;
            y = y - dy;
            a = a + arctan_units[i];
         end else begin
            x = x - dx;
            y = y + dy;
            a = a - arctan_units[i];
         end
      end
      u = a + HALF_TURN_UNITS;
      if (u < 0) u = 0;
      if (u > FULL_TURN_UNITS) u = FULL_TURN_UNITS;
      d = (u * 360) >>> 32;
      if (d > 360) d = 360;
      return d[8:0];
   endfunction

   function automatic rsp_word_type predict_angle_word(req_word_type w);
      logic signed [11:0] xs;
      logic signed [11:0] ys;
      rsp_word_type       r;
      int                 error;
      xs = {w.x_high_byte, w.xy_low_nibbles[7:4]};
      ys = {w.y_high_byte, w.xy_low_nibbles[3:0]};
      r.angle_degree = cordic_degrees(xs, ys);
      error = int'(r.angle_degree) - int'(target_setting);
      if (error < 0) error = -error;
      r.motor_run = (error > int'(tolerance_setting));
      return r;
   endfunction

   function automatic req_word_type pack_sample(logic [11:0] x_field, logic [11:0] y_field);
      return '{x_field[11:4], y_field[11:4], {x_field[3:0], y_field[3:0]}};
   endfunction

   function automatic req_word_type random_sample();
      logic [11:0] x_field;
      logic [11:0] y_field;
      logic [3:0]  s;
      x_field = 12'($urandom);
      y_field = 12'($urandom);
      case ($urandom_range(0, 9))
         0: x_field = '0;
         1: y_field = '0;
         2: begin
            s = 4'($urandom);
            x_field = {{8{s[3]}}, s};
            s = 4'($urandom);
            y_field = {{8{s[3]}}, s};
         end
         default: ;
      endcase
      return pack_sample(x_field, y_field);
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      mismatch_count++;
      $display("%0t: %s mismatch: got %0d, want %0d", $realtime, what, got, want);
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (pending_angles.size() == 0) begin
               report_mismatch("unexpected rsp word", int'(rsp_data.angle_degree), -1);
            end else begin
               wanted_word = pending_angles.pop_front();
               if (rsp_data.angle_degree !== wanted_word.angle_degree)
                  report_mismatch("angle_degree", int'(rsp_data.angle_degree),
                                  int'(wanted_word.angle_degree));
               if (rsp_data.motor_run !== wanted_word.motor_run)
                  report_mismatch("motor_run", int'(rsp_data.motor_run),
                                  int'(wanted_word.motor_run));
            end
         end
         if (req_valid && req_ready) begin
            sent_note = pending_notes.pop_front();
            pending_angles.push_back(sent_note.known ? sent_note.word
                                                     : predict_angle_word(req_data));
         end
      end
   end

   task automatic send_word(input req_word_type w, input bit known, input rsp_word_type typed);
      note_type n;
      n.known = known;
      n.word = typed;
      pending_notes.push_back(n);
      req_valid <= 1'b1;
      req_data <= w;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic sender_gap(input int cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic drain_block();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_angles.size() != 0 || pending_notes.size() != 0);
   endtask

   task automatic write_settings(input logic [8:0] target, input logic [8:0] tolerance);
      csr_we <= 1'b1;
      csr_index <= CSR_TARGET_DEGREE;
      csr_wdata <= target;
      @(posedge clock);
      csr_index <= CSR_TOLERANCE_DEGREES;
      csr_wdata <= tolerance;
      @(posedge clock);
      csr_we <= 1'b0;
      target_setting = target;
      tolerance_setting = tolerance;
   endtask

   task automatic run_random_phase(input logic [8:0] target, input logic [8:0] tolerance,
                                   input int count, input bit steady, input bit mid_pause);
      int burst_left;
      int i;
      write_settings(target, tolerance);
      burst_left = $urandom_range(1, 30);
      for (i = 0; i < count; i++) begin
         send_word(random_sample(), 1'b0, '0);
         if (mid_pause && i == count / 2) begin
            drain_block();
         end else if (!steady) begin
            burst_left--;
            if (burst_left == 0) begin
               sender_gap($urandom_range(1, 12));
               burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80)
                                                        : $urandom_range(1, 20);
            end
         end
      end
      drain_block();
   endtask

   initial begin
      int          stretch;
      int          mode;
      int          k;
      logic        ready_now;
      forever begin
         if (hold_wanted && !hold_done) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_done = 1'b1;
         end else begin
            stretch = $urandom_range(1, 40);
            mode = $urandom_range(0, 4);
            for (k = 0; k < stretch; k++) begin
               case (mode)
                  0, 1: ready_now = 1'b1;
                  2: ready_now = 1'($urandom_range(0, 1));
                  3: ready_now = ($urandom_range(0, 4) == 0);
                  default: ready_now = ($urandom_range(0, 3) != 0);
               endcase
               rsp_ready <= ready_now;
               @(posedge clock);
            end
         end
      end
   end

   initial begin
      int i;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      for (i = 0; i < 24; i++) begin
         send_word(pack_sample(directed_rows[i].x_field, directed_rows[i].y_field),
                   directed_rows[i].known, '{directed_rows[i].angle, directed_rows[i].run});
         if ($urandom_range(0, 2) == 0) sender_gap($urandom_range(1, 4));
      end
      drain_block();

      run_random_phase(9'd0, 9'd0, 130, 1'b0, 1'b0);
      hold_wanted = 1'b1;
      run_random_phase(9'd360, 9'd360, 150, 1'b1, 1'b0);
      run_random_phase(9'd511, 9'd511, 100, 1'b0, 1'b0);
      run_random_phase(9'd180, 9'd0, 140, 1'b0, 1'b1);
      run_random_phase(9'($urandom_range(0, 511)), 9'($urandom_range(0, 30)), 130, 1'b0, 1'b0);
      run_random_phase(9'($urandom_range(0, 360)), 9'($urandom_range(0, 360)), 130, 1'b0, 1'b0);

      repeat (CORDIC_STEPS + 8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   initial begin
      #(5_000_000);
      $display("Verification failed");
      $finish;
   end

endmodule

`default_nettype wire
